### rtl/las_pkg.sv
package las_pkg;

  localparam int RESIDUE_W      = 8;
  localparam int SCORE_W        = 10;
  localparam int QUERY_END_W    = 7;
  localparam int DATABASE_END_W = 13;
  localparam int MATCH_W        = 4;
  localparam int PENALTY_W      = 10;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 10;
  // Signed width for cell arithmetic: covers ceiling + match and -penalty.
  localparam int CALC_W         = 12;

  localparam logic [SCORE_W-1:0] SCORE_CEILING = 10'd1023;

  localparam logic CMD_QUERY    = 1'b0;
  localparam logic CMD_DATABASE = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_MATCH    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MISMATCH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAP      = 2'd2;

  localparam logic [MATCH_W-1:0]   MATCH_RESET    = 4'd1;
  localparam logic [PENALTY_W-1:0] MISMATCH_RESET = 10'd1023;
  localparam logic [PENALTY_W-1:0] GAP_RESET      = 10'd1023;

  typedef struct packed {
    logic [MATCH_W-1:0]   match_score;
    logic [PENALTY_W-1:0] mismatch_penalty;
    logic [PENALTY_W-1:0] gap_penalty;
  } las_cfg_t;

  // Control that travels with each step of the cell chain.
  typedef struct packed {
    logic valid;  // a database residue to score
    logic token;  // end of job: collect the best cell, clear the cell
  } las_ctl_t;

endpackage

### rtl/las_if.sv
interface las_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [las_pkg::RESIDUE_W-1:0] residue;
  logic                          last;

  modport source (output valid, command, residue, last, input ready);
  modport sink   (input valid, command, residue, last, output ready);
endinterface

interface las_out_if;
  logic                               valid;
  logic                               ready;
  logic [las_pkg::SCORE_W-1:0]        best_score;
  logic [las_pkg::QUERY_END_W-1:0]    query_end;
  logic [las_pkg::DATABASE_END_W-1:0] database_end;
  logic                               truncated;

  modport source (output valid, best_score, query_end, database_end, truncated,
                  input ready);
  modport sink   (input valid, best_score, query_end, database_end, truncated,
                  output ready);
endinterface

interface las_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [las_pkg::CFG_INDEX_W-1:0] index;
  logic [las_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/las_cell.sv
module las_cell #(
  parameter int INDEX = 0,
  parameter int QW    = 7,
  parameter int DW    = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  las_pkg::las_cfg_t             cfg,
  input  logic                          load_en,
  input  logic [las_pkg::RESIDUE_W-1:0] load_residue,
  input  las_pkg::las_ctl_t             in_ctl,
  input  logic [las_pkg::RESIDUE_W-1:0] in_residue,
  input  logic [DW-1:0]                 in_db,
  input  logic [las_pkg::SCORE_W-1:0]   in_up,
  input  logic [las_pkg::SCORE_W-1:0]   in_run_score,
  input  logic [QW-1:0]                 in_run_q,
  input  logic [DW-1:0]                 in_run_db,
  output las_pkg::las_ctl_t             out_ctl,
  output logic [las_pkg::RESIDUE_W-1:0] out_residue,
  output logic [DW-1:0]                 out_db,
  output logic [las_pkg::SCORE_W-1:0]   out_up,
  output logic [las_pkg::SCORE_W-1:0]   out_run_score,
  output logic [QW-1:0]                 out_run_q,
  output logic [DW-1:0]                 out_run_db
);
  import las_pkg::*;

  logic [RESIDUE_W-1:0] query;
  logic                 loaded;
  logic [SCORE_W-1:0]   h;         // H(i, j-1)
  logic [SCORE_W-1:0]   last_up;   // H(i-1, j-1)
  logic [SCORE_W-1:0]   best_score;
  logic [DW-1:0]        best_db;

  logic signed [CALC_W-1:0] s_diag, s_up, s_left, s_max;
  logic [SCORE_W-1:0]       score;
  logic                     score_act;
  logic [SCORE_W-1:0]       own_score;
  logic [DW-1:0]            own_db;

  always_comb begin
    if (query == in_residue) begin
      s_diag = signed'({2'b00, last_up}) + signed'({8'b0, cfg.match_score});
    end else begin
      s_diag = signed'({2'b00, last_up}) - signed'({2'b00, cfg.mismatch_penalty});
    end
    s_up   = signed'({2'b00, in_up}) - signed'({2'b00, cfg.gap_penalty});
    s_left = signed'({2'b00, h}) - signed'({2'b00, cfg.gap_penalty});
    s_max  = s_diag;
    if (s_up > s_max) begin
      s_max = s_up;
    end
    if (s_left > s_max) begin
      s_max = s_left;
    end
    if (s_max < 0) begin
      score = '0;
    end else if (s_max > signed'({2'b00, SCORE_CEILING})) begin
      score = SCORE_CEILING;
    end else begin
      score = s_max[SCORE_W-1:0];
    end

    score_act = in_ctl.valid && loaded;
    // Strictly greater keeps the earliest database position on ties.
    if (score_act && (score > best_score)) begin
      own_score = score;
      own_db    = in_db;
    end else begin
      own_score = best_score;
      own_db    = best_db;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded     <= 1'b0;
      h          <= '0;
      last_up    <= '0;
      best_score <= '0;
      out_ctl    <= '0;
    end else begin
      out_ctl <= in_ctl;
      if (in_ctl.token) begin
        loaded     <= 1'b0;
        h          <= '0;
        last_up    <= '0;
        best_score <= '0;
      end else begin
        if (load_en) begin
          loaded <= 1'b1;
        end
        if (score_act) begin
          h          <= score;
          last_up    <= in_up;
          best_score <= own_score;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      query <= load_residue;
    end
    if (score_act) begin
      best_db <= own_db;
    end
    out_residue <= in_residue;
    out_db      <= in_db;
    out_up      <= score;
    // Ties keep the running best: it comes from a smaller query position.
    if (own_score > in_run_score) begin
      out_run_score <= own_score;
      out_run_q     <= QW'(INDEX + 1);
      out_run_db    <= own_db;
    end else begin
      out_run_score <= in_run_score;
      out_run_q     <= in_run_q;
      out_run_db    <= in_run_db;
    end
  end

endmodule

### rtl/local_alignment_score.sv
// Throughput: one query or database residue per cycle while a job streams in; after the
//   last database residue, input holds while the cell chain drains, and a final database
//   residue also waits while the previous result has not been taken.
// Chain of MAX_QUERY cells, one query residue each; a database residue moves one cell a cycle.
// Reset (synchronous, rst high) returns cell scores, counters, flags and configuration
//   registers to their defaults; query residues, chain and result data are not reset.
module local_alignment_score #(
  parameter int MAX_QUERY    = 64,
  parameter int MAX_DATABASE = 4096
) (
  input logic  clk,
  input logic  rst,
  las_in_if.sink    in_item,
  las_out_if.source result,
  las_cfg_if.sink   cfg
);
  import las_pkg::*;

  localparam int QW = $clog2(MAX_QUERY + 1);
  localparam int DW = $clog2(MAX_DATABASE + 1);

  // Configuration registers.
  las_cfg_t cfg_regs;

  // Job state.
  logic [QW-1:0] query_length;
  logic [DW-1:0] database_position;
  logic          overflow_seen;
  logic          trunc_pending;   // truncation flag of the job now draining
  logic          draining;        // end token still travels the chain

  // Result register.
  logic                 res_valid;
  logic [SCORE_W-1:0]   res_score;
  logic [QW-1:0]        res_q;
  logic [DW-1:0]        res_db;
  logic                 res_trunc;

  // Cell chain links; entry 0 is the chain input.
  las_ctl_t             link_ctl       [MAX_QUERY+1];
  logic [RESIDUE_W-1:0] link_residue   [MAX_QUERY+1];
  logic [DW-1:0]        link_db        [MAX_QUERY+1];
  logic [SCORE_W-1:0]   link_up        [MAX_QUERY+1];
  logic [SCORE_W-1:0]   link_run_score [MAX_QUERY+1];
  logic [QW-1:0]        link_run_q     [MAX_QUERY+1];
  logic [DW-1:0]        link_run_db    [MAX_QUERY+1];
  logic [MAX_QUERY-1:0] load_en;

  logic in_acc;
  logic query_load;
  logic db_item;
  logic db_scored;

  // Configuration: always ready, unknown indexes drop the write.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.match_score      <= MATCH_RESET;
      cfg_regs.mismatch_penalty <= MISMATCH_RESET;
      cfg_regs.gap_penalty      <= GAP_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MATCH:    cfg_regs.match_score      <= cfg.data[MATCH_W-1:0];
        REG_MISMATCH: cfg_regs.mismatch_penalty <= cfg.data[PENALTY_W-1:0];
        REG_GAP:      cfg_regs.gap_penalty      <= cfg.data[PENALTY_W-1:0];
        default:      ;
      endcase
    end
  end

  // Hold input while the chain drains, and hold a final database residue
  // while the previous result still waits, so the end token always lands
  // in a free result register.
  assign in_item.ready = !draining &&
                         !(res_valid && (in_item.command == CMD_DATABASE) && in_item.last);
  assign in_acc        = in_item.valid && in_item.ready;

  // Query residues count only before the first database residue.
  assign query_load = in_acc && (in_item.command == CMD_QUERY) && (database_position == '0)
                      && (query_length < QW'(MAX_QUERY));
  assign db_item    = in_acc && (in_item.command == CMD_DATABASE);
  assign db_scored  = database_position < DW'(MAX_DATABASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      query_length      <= '0;
      database_position <= '0;
      overflow_seen     <= 1'b0;
      trunc_pending     <= 1'b0;
      draining          <= 1'b0;
    end else begin
      if (in_acc && (in_item.command == CMD_QUERY) && (database_position == '0)) begin
        if (query_load) begin
          query_length <= query_length + 1'b1;
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (db_item) begin
        if (in_item.last) begin
          // Close the job: hand the flag to the draining token, clear counters.
          trunc_pending     <= overflow_seen || !db_scored;
          query_length      <= '0;
          database_position <= '0;
          overflow_seen     <= 1'b0;
          draining          <= 1'b1;
        end else if (db_scored) begin
          database_position <= database_position + 1'b1;
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (link_ctl[MAX_QUERY].token) begin
        draining <= 1'b0;
      end
    end
  end

  // Chain input: row zero boundary is all zero scores.
  always_comb begin
    link_ctl[0].valid = db_item && db_scored;
    link_ctl[0].token = db_item && in_item.last;
  end
  assign link_residue[0]   = in_item.residue;
  assign link_db[0]        = database_position + 1'b1;
  assign link_up[0]        = '0;
  assign link_run_score[0] = '0;
  assign link_run_q[0]     = '0;
  assign link_run_db[0]    = '0;

  for (genvar g = 0; g < MAX_QUERY; g++) begin : g_cell
    assign load_en[g] = query_load && (query_length == QW'(g));

    las_cell #(
      .INDEX (g),
      .QW    (QW),
      .DW    (DW)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .cfg           (cfg_regs),
      .load_en       (load_en[g]),
      .load_residue  (in_item.residue),
      .in_ctl        (link_ctl[g]),
      .in_residue    (link_residue[g]),
      .in_db         (link_db[g]),
      .in_up         (link_up[g]),
      .in_run_score  (link_run_score[g]),
      .in_run_q      (link_run_q[g]),
      .in_run_db     (link_run_db[g]),
      .out_ctl       (link_ctl[g+1]),
      .out_residue   (link_residue[g+1]),
      .out_db        (link_db[g+1]),
      .out_up        (link_up[g+1]),
      .out_run_score (link_run_score[g+1]),
      .out_run_q     (link_run_q[g+1]),
      .out_run_db    (link_run_db[g+1])
    );
  end

  // Result register: capture the token leaving the last cell, hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (link_ctl[MAX_QUERY].token) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (link_ctl[MAX_QUERY].token) begin
      res_score <= link_run_score[MAX_QUERY];
      res_q     <= link_run_q[MAX_QUERY];
      res_db    <= link_run_db[MAX_QUERY];
      res_trunc <= trunc_pending;
    end
  end

  assign result.valid        = res_valid;
  assign result.best_score   = res_score;
  assign result.query_end    = QUERY_END_W'(res_q);
  assign result.database_end = DATABASE_END_W'(res_db);
  assign result.truncated    = res_trunc;

endmodule

### bench/las_score_checker.sv
module las_score_checker #(
  parameter int QUERY_CAP    = 64,
  parameter int DATABASE_CAP = 4096
) (
  input  logic clk,
  input  logic rst,
  las_in_if    in_mon,
  las_out_if   res_mon,
  las_cfg_if   cfg_mon,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import las_pkg::*;

  typedef struct packed {
    logic [SCORE_W-1:0]        best_score;
    logic [QUERY_END_W-1:0]    query_end;
    logic [DATABASE_END_W-1:0] database_end;
    logic                      truncated;
  } alignment_t;

  alignment_t           pending_alignments [$];
  logic [RESIDUE_W-1:0] query_residues [QUERY_CAP];
  int                   column_h [QUERY_CAP];
  int                   query_len;
  int                   db_pos;
  int                   top_score;
  int                   top_query;
  int                   top_db;
  bit                   overflowed;
  las_cfg_t             weights;
  int                   bad_count;

  function automatic void clear_job();
    foreach (column_h[i]) column_h[i] = 0;
    query_len  = 0;
    db_pos     = 0;
    top_score  = 0;
    top_query  = 0;
    top_db     = 0;
    overflowed = 1'b0;
  endfunction

  // One database residue fills one column of the score matrix.
  function automatic void score_column(logic [RESIDUE_W-1:0] res);
    int diag;
    int up;
    int left;
    int h_new;
    int side;
    diag = 0;
    up   = 0;
    for (int i = 0; i < query_len; i++) begin
      left = column_h[i];
      if (query_residues[i] == res) h_new = diag + int'(weights.match_score);
      else h_new = diag - int'(weights.mismatch_penalty);
      side = up - int'(weights.gap_penalty);
      if (side > h_new) h_new = side;
      side = left - int'(weights.gap_penalty);
      if (side > h_new) h_new = side;
      if (h_new < 0) h_new = 0;
      if (h_new > int'(SCORE_CEILING)) h_new = int'(SCORE_CEILING);
      column_h[i] = h_new;
      diag = left;
      up   = h_new;
      // ties keep the smaller query position, then the earlier column
      if (h_new > top_score || (h_new > 0 && h_new == top_score && i + 1 < top_query)) begin
        top_score = h_new;
        top_query = i + 1;
        top_db    = db_pos;
      end
    end
  endfunction

  function automatic void take_residue(logic cmd, logic [RESIDUE_W-1:0] res, logic lst);
    alignment_t done;
    if (cmd == CMD_QUERY) begin
      // query residues count only before the first database residue
      if (db_pos == 0) begin
        if (query_len < QUERY_CAP) begin
          query_residues[query_len] = res;
          query_len++;
        end else begin
          overflowed = 1'b1;
        end
      end
    end else begin
      if (db_pos < DATABASE_CAP) begin
        db_pos++;
        score_column(res);
      end else begin
        overflowed = 1'b1;
      end
      if (lst) begin
        done.best_score   = top_score[SCORE_W-1:0];
        done.query_end    = top_query[QUERY_END_W-1:0];
        done.database_end = top_db[DATABASE_END_W-1:0];
        done.truncated    = overflowed;
        pending_alignments.push_back(done);
        clear_job();
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    alignment_t got;
    alignment_t want;
    if (rst) begin
      pending_alignments.delete();
      clear_job();
      weights = '{match_score: MATCH_RESET, mismatch_penalty: MISMATCH_RESET,
                  gap_penalty: GAP_RESET};
      bad_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_MATCH:    weights.match_score      = cfg_mon.data[MATCH_W-1:0];
          REG_MISMATCH: weights.mismatch_penalty = cfg_mon.data[PENALTY_W-1:0];
          REG_GAP:      weights.gap_penalty      = cfg_mon.data[PENALTY_W-1:0];
          default: ;
        endcase
      end
      // compare before taking a new residue, so a result never meets its own job
      if (res_mon.valid && res_mon.ready) begin
        got.best_score   = res_mon.best_score;
        got.query_end    = res_mon.query_end;
        got.database_end = res_mon.database_end;
        got.truncated    = res_mon.truncated;
        if (pending_alignments.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t unexpected result: score %0d query_end %0d", $time,
                     got.best_score, got.query_end,
                     " database_end %0d trunc %0b", got.database_end, got.truncated);
        end else begin
          want = pending_alignments.pop_front();
          if (got.best_score !== want.best_score || got.query_end !== want.query_end ||
              got.database_end !== want.database_end || got.truncated !== want.truncated) begin
            bad_count++;
            if (bad_count <= 10)
              $display("%0t mismatch: expected score %0d query_end %0d", $time,
                       want.best_score, want.query_end,
                       " database_end %0d trunc %0b,", want.database_end, want.truncated,
                       " got score %0d query_end %0d", got.best_score, got.query_end,
                       " database_end %0d trunc %0b", got.database_end, got.truncated);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        take_residue(in_mon.command, in_mon.residue, in_mon.last);
    end
    mismatches  <= bad_count;
    outstanding <= pending_alignments.size();
  end

endmodule

### bench/tb_local_alignment_score.sv
module tb_local_alignment_score;
  timeunit 1ns;
  timeprecision 1ps;
  import las_pkg::*;

  localparam int QUERY_CAP      = 64;
  localparam int DATABASE_CAP   = 4096;
  localparam int RANDOM_ITEMS   = 1850;
  localparam int HOLDOFF_CYCLES = 300;
  // covers the drain of the cell chain after the last database residue, with margin
  localparam int DRAIN_CYCLES   = QUERY_CAP + 16;
  // index with no register behind it; writes there must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   quiet;        // no idle cycles on either side while set
  bit   hold_go;      // ask the receiver for one long hold-off
  bit   hold_taken;   // written by the receiver only
  int   items_pushed;
  int   mismatches;
  int   outstanding;

  las_in_if  in_bus ();
  las_out_if res_bus ();
  las_cfg_if cfg_bus ();

  local_alignment_score #(
    .MAX_QUERY    (QUERY_CAP),
    .MAX_DATABASE (DATABASE_CAP)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_bus),
    .result  (res_bus),
    .cfg     (cfg_bus)
  );

  las_score_checker #(
    .QUERY_CAP    (QUERY_CAP),
    .DATABASE_CAP (DATABASE_CAP)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_mon      (in_bus),
    .res_mon     (res_bus),
    .cfg_mon     (cfg_bus),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  // Hard stop: far beyond the slowest legal run, gaps and drains included.
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // Idle length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 20);
  endfunction

  // Draw mostly from a small per-job alphabet so that runs of matches occur.
  function automatic logic [RESIDUE_W-1:0] draw_residue(input logic [RESIDUE_W-1:0] letters [4],
                                                       input int span);
    if ($urandom_range(0, 4) == 0) return RESIDUE_W'($urandom_range(0, 255));
    return letters[$urandom_range(0, span)];
  endfunction

  // Offer one residue transaction after a random idle stretch; return at the
  // falling edge after acceptance, leaving valid high for a back-to-back item.
  task automatic push_residue(logic cmd, logic [RESIDUE_W-1:0] res, logic lst);
    int idle;
    idle = pick_gap();
    if (idle > 0) begin
      in_bus.valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.command <= cmd;
    in_bus.residue <= res;
    in_bus.last    <= lst;
    do @(posedge clk); while (!in_bus.ready);
    items_pushed++;
    @(negedge clk);
  endtask

  // Leave cfg valid high; the caller drops it after its last write.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
  endtask

  // Pause the sender until every result is back, then let the chain drain.
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_weights(logic [MATCH_W-1:0] m, logic [PENALTY_W-1:0] mm,
                             logic [PENALTY_W-1:0] g);
    logic [CFG_DATA_W-1:0] filler;
    settle();
    // upper data bits of the match write are don't-care; keep them random
    filler = CFG_DATA_W'($urandom);
    filler[MATCH_W-1:0] = m;
    write_reg(REG_MATCH, filler);
    write_reg(REG_MISMATCH, mm);
    write_reg(REG_GAP, g);
    if ($urandom_range(0, 1)) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_bus.valid <= 1'b0;
  endtask

  // One job: qn query residues, then dn database residues, the last one flagged.
  task automatic run_job(int qn, int dn);
    logic [RESIDUE_W-1:0] letters [4];
    int span;
    span = $urandom_range(1, 3);
    foreach (letters[k]) letters[k] = RESIDUE_W'($urandom_range(0, 255));
    // the last flag on the query side means nothing; toggle it freely
    for (int k = 0; k < qn; k++)
      push_residue(CMD_QUERY, draw_residue(letters, span),
                   (k == qn - 1) ? 1'b1 : ($urandom_range(0, 7) == 0));
    for (int k = 0; k < dn; k++) begin
      push_residue(CMD_DATABASE, draw_residue(letters, span), k == dn - 1);
      // stray query transaction inside the database stream; the block drops it
      if (k < dn - 1 && $urandom_range(0, 19) == 0)
        push_residue(CMD_QUERY, RESIDUE_W'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
    end
  endtask

  // Receiver: random ready with one long hold-off on request, so that the
  // result stalls and the final database residue of a later job gets refused.
  initial begin : receiver
    int idle;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        res_bus.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end else begin
        idle = pick_gap();
        if (idle > 0) begin
          res_bus.ready <= 1'b0;
          repeat (idle) @(negedge clk);
        end
        res_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int phase;
    int goal;
    int qn;
    int dn;
    int r;
    logic [PENALTY_W-1:0] mm;
    logic [PENALTY_W-1:0] g;
    in_bus.valid   = 1'b0;
    in_bus.command = CMD_QUERY;
    in_bus.residue = '0;
    in_bus.last    = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = REG_MATCH;
    cfg_bus.data   = '0;
    quiet          = 1'b0;
    hold_go        = 1'b0;
    items_pushed   = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset weights: exact runs only, i.e. longest common substring.
    // Empty query: the database residue scores nothing.
    push_residue(CMD_DATABASE, 8'hFF, 1'b1);
    // Query with a flagged last residue (ignored), a stray query transaction
    // after the database has started (dropped), and equal-length ties.
    push_residue(CMD_QUERY, 8'h00, 1'b0);
    push_residue(CMD_QUERY, 8'hFF, 1'b0);
    push_residue(CMD_QUERY, 8'h41, 1'b0);
    push_residue(CMD_QUERY, 8'h42, 1'b1);
    push_residue(CMD_DATABASE, 8'h41, 1'b0);
    push_residue(CMD_QUERY, 8'h7E, 1'b1);
    push_residue(CMD_DATABASE, 8'h42, 1'b0);
    push_residue(CMD_DATABASE, 8'hFF, 1'b0);
    push_residue(CMD_DATABASE, 8'h00, 1'b1);
    // No positive cell anywhere.
    push_residue(CMD_QUERY, 8'h10, 1'b0);
    push_residue(CMD_DATABASE, 8'h20, 1'b1);

    // Largest match, free mismatches and gaps.
    set_weights(4'd15, 10'd0, 10'd0);
    push_residue(CMD_QUERY, 8'hAA, 1'b0);
    push_residue(CMD_QUERY, 8'h55, 1'b0);
    push_residue(CMD_QUERY, 8'hAA, 1'b1);
    push_residue(CMD_DATABASE, 8'h55, 1'b0);
    push_residue(CMD_DATABASE, 8'hAA, 1'b0);
    push_residue(CMD_DATABASE, 8'h55, 1'b0);
    push_residue(CMD_DATABASE, 8'hAA, 1'b1);

    // Zero match: every cell stays at zero.
    set_weights(4'd0, 10'd1023, 10'd0);
    push_residue(CMD_QUERY, 8'h01, 1'b0);
    push_residue(CMD_DATABASE, 8'h01, 1'b1);

    // Over-long query: flags truncation.
    set_weights(MATCH_RESET, 10'd0, 10'd1023);
    run_job(QUERY_CAP + 5, 6);

    // Random phases, each under its own weights; phase 2 carries the hold-off.
    goal  = items_pushed + RANDOM_ITEMS;
    phase = 0;
    while (items_pushed < goal || phase < 3) begin
      case (phase % 6)
        0: set_weights(MATCH_RESET, MISMATCH_RESET, GAP_RESET);
        1: set_weights(4'd15, 10'd0, 10'd0);
        2: set_weights(4'd1, 10'd1, 10'd1);
        3: set_weights(4'd15, 10'd1023, 10'd1023);
        4: set_weights(4'd2, 10'd0, 10'd1023);
        default: begin
          // small penalties give interesting alignments; large ones forbid
          mm = $urandom_range(0, 1) ? PENALTY_W'($urandom_range(0, 6))
                                    : PENALTY_W'($urandom_range(0, 1023));
          g  = $urandom_range(0, 1) ? PENALTY_W'($urandom_range(0, 6))
                                    : PENALTY_W'($urandom_range(0, 1023));
          set_weights(MATCH_W'($urandom_range(0, 15)), mm, g);
        end
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        quiet   = 1'b0;
        hold_go = 1'b1;
      end
      repeat ($urandom_range(4, 10)) begin
        r = $urandom_range(0, 99);
        if (r < 4) qn = 0;
        else if (r < 86) qn = $urandom_range(1, 12);
        else if (r < 97) qn = $urandom_range(13, QUERY_CAP);
        else qn = $urandom_range(QUERY_CAP + 1, QUERY_CAP + 6);
        dn = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
        run_job(qn, dn);
      end
      phase++;
    end

    quiet = 1'b0;
    settle();
    if (mismatches == 0 && outstanding == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
